### design/wcld_pkg.sv
// Shared constants for the word CRC long-division unit.
package wcld_pkg;

  // Fixed field widths
  localparam int unsigned PolyBits = 16;
  localparam int unsigned DataBits = 16;
  localparam int unsigned CrcBits  = 16;

  // Generator polynomial after reset
  localparam logic [PolyBits-1:0] PolyReset = 16'h8005;

  // Table builder state codes
  localparam logic [1:0] ST_NORM  = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_READY = 2'd2;

endpackage

### design/word_crc_long_division_unit.sv
// Top level of the word CRC long-division unit.
//
// Takes one message word per cycle while in_ready_o is high and gives one result per
// last word: the zero-init, MSB-first CRC of the message times x^WORD_BITS, left-aligned
// in the word, plus a zero flag. An accepted last word passes the input stage register
// and then the result register. Throughput is one word per clock unless a last word meets
// a full result register, set by a combinational XOR reduction of the word against a
// table of WORD_BITS columns x^(WORD_BITS+k) mod G held in flip-flops, rebuilt after reset
// and every poly write (top bit aligned, then columns built) while in_ready_o stays low.
module word_crc_long_division_unit #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wcld_pkg::PolyBits-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wcld_pkg::DataBits-1:0]  data_word_i,
  input  logic                           last_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wcld_pkg::CrcBits-1:0]   crc_o,
  output logic                           crc_is_zero_o
);

  logic [WORD_BITS-1:0] cols [WORD_BITS];
  logic                 table_ready;

  // Reduction table
  wcld_table_builder #(
    .WORD_BITS(WORD_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cols_o     (cols),
    .ready_o    (table_ready)
  );

  // Word datapath
  wcld_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .table_ready_i(table_ready),
    .cols_i       (cols),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .crc_o        (crc_o),
    .crc_is_zero_o(crc_is_zero_o)
  );

endmodule

### design/wcld_table_builder.sv
// Builds the reduction table x^(W+k) mod G, one column per cycle, after reset or a poly write.
module wcld_table_builder #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wcld_pkg::PolyBits-1:0]   cfg_wdata_i,
  output logic [WORD_BITS-1:0]            cols_o [WORD_BITS],
  output logic                            ready_o
);

  localparam int unsigned CntW = $clog2(WORD_BITS);

  logic [1:0]           state_q, state_d;
  logic [WORD_BITS-1:0] p_q, p_d;
  logic [WORD_BITS-1:0] g_q, g_d;
  logic [WORD_BITS-1:0] cur_q, cur_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WORD_BITS-1:0] cols_q [WORD_BITS];
  logic                 push;

  // Normalize the polynomial, then step the column recurrence
  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    g_d     = g_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    push    = 1'b0;
    unique case (state_q)
      wcld_pkg::ST_NORM: begin
        if ((p_q == '0) || p_q[WORD_BITS-1]) begin
          // top bit aligned to x^W; drop it to keep the low part of G
          g_d     = {p_q[WORD_BITS-2:0], 1'b0};
          cur_d   = {p_q[WORD_BITS-2:0], 1'b0};
          cnt_d   = '0;
          state_d = wcld_pkg::ST_BUILD;
        end else begin
          p_d = {p_q[WORD_BITS-2:0], 1'b0};
        end
      end
      wcld_pkg::ST_BUILD: begin
        push  = 1'b1;
        cur_d = {cur_q[WORD_BITS-2:0], 1'b0} ^ (cur_q[WORD_BITS-1] ? g_q : '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(WORD_BITS - 1)) begin
          state_d = wcld_pkg::ST_READY;
        end
      end
      wcld_pkg::ST_READY: begin
        state_d = wcld_pkg::ST_READY;
      end
      default: begin
        state_d = wcld_pkg::ST_NORM;
      end
    endcase
    // A poly write restarts the whole build
    if (cfg_we_i) begin
      p_d     = WORD_BITS'(cfg_wdata_i);
      state_d = wcld_pkg::ST_NORM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wcld_pkg::ST_NORM;
      p_q     <= WORD_BITS'(wcld_pkg::PolyReset);
      g_q     <= '0;
      cur_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      g_q     <= g_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
    end
  end

  // Shift columns in; the first one pushed ends at index 0
  always_ff @(posedge clk_i) begin
    if (push) begin
      for (int i = 0; i < WORD_BITS - 1; i++) begin
        cols_q[i] <= cols_q[i+1];
      end
      cols_q[WORD_BITS-1] <= cur_q;
    end
  end

  assign cols_o  = cols_q;
  assign ready_o = (state_q == wcld_pkg::ST_READY);

endmodule

### design/wcld_datapath.sv
// Input stage, one-word XOR reduction against the table, carry word and result register.
module wcld_datapath #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           table_ready_i,
  input  logic [WORD_BITS-1:0]           cols_i [WORD_BITS],
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wcld_pkg::DataBits-1:0]  data_word_i,
  input  logic                           last_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wcld_pkg::CrcBits-1:0]   crc_o,
  output logic                           crc_is_zero_o
);

  logic                          s1_valid_q, s1_valid_d;
  logic [WORD_BITS-1:0]          s1_data_q;
  logic                          s1_last_q;
  logic [WORD_BITS-1:0]          carry_q, carry_d;
  logic                          out_valid_q, out_valid_d;
  logic [wcld_pkg::CrcBits-1:0]  crc_q;
  logic                          zero_q;
  logic                          s1_go;
  logic                          accept;
  logic [WORD_BITS-1:0]          dividend;
  logic [WORD_BITS-1:0]          rem;

  // Advance the input stage unless a last item meets a full result register
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = table_ready_i && (!s1_valid_q || s1_go);
  assign accept     = in_valid_i && in_ready_o;

  // Remainder of (carry ^ data) * x^W: XOR of the table columns selected by each bit
  assign dividend = carry_q ^ s1_data_q;
  always_comb begin
    rem = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      rem = rem ^ (dividend[i] ? cols_i[i] : '0);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    carry_d = carry_q;
    if (s1_go) begin
      carry_d = s1_last_q ? '0 : rem;
    end
    out_valid_d = out_valid_q;
    if (s1_go && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item and the finished remainder
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= WORD_BITS'(data_word_i);
      s1_last_q <= last_word_i;
    end
    if (s1_go && s1_last_q) begin
      crc_q  <= wcld_pkg::CrcBits'(rem);
      zero_q <= (rem == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign crc_o         = crc_q;
  assign crc_is_zero_o = zero_q;

endmodule

### design/wcld_checker.sv
// Port-level checks for the word CRC long-division unit, bound to the top level.
module wcld_checker #(
  parameter int unsigned WORD_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           last_word_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [wcld_pkg::CrcBits-1:0]   crc_o,
  input logic                           crc_is_zero_o
);

  // Hold a stalled result item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(crc_o) && $stable(crc_is_zero_o))
    else $error("stalled result item changed");

  // Zero flag agrees with the remainder when the word fits the crc port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (WORD_BITS <= wcld_pkg::CrcBits) |-> crc_is_zero_o == (crc_o == '0))
    else $error("zero flag disagrees with crc");

  // Ready must be low after a poly write, while the table rebuilds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o ##1 !in_ready_o)
    else $error("item accepted during table rebuild");

  // A new result only follows an accepted last item that passed the input stage register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_word_i, 2))
    else $error("result item without a last item");

endmodule

bind word_crc_long_division_unit wcld_checker #(
  .WORD_BITS(WORD_BITS)
) u_wcld_checker (.*);

### sim/word_crc_long_division_unit_tb.sv
// Self-checking testbench for the word CRC long-division unit.
module word_crc_long_division_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataBits    = wcld_pkg::DataBits;
  localparam int unsigned CrcBits     = wcld_pkg::CrcBits;
  localparam int unsigned PolyBits    = wcld_pkg::PolyBits;
  localparam int unsigned WordBits    = DataBits;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted  = 40;
  localparam int unsigned MaxMsgLen   = 32;

  typedef struct packed {
    logic [CrcBits-1:0] crc;
    logic               zero;
  } crc_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [PolyBits-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [DataBits-1:0] data_word_i;
  logic                last_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CrcBits-1:0]  crc_o;
  logic                crc_is_zero_o;

  // Model of the block: aligned generator, running remainder
  logic [WordBits-1:0] gen_low;
  logic [WordBits-1:0] running_rem;
  crc_result_t         crc_expect_q[$];
  int unsigned         mismatches = 0;

  // Sender and receiver pacing
  bit                  sender_gaps = 1'b1;
  int unsigned         burst_left  = 0;
  int unsigned         hold_request = 0;
  int unsigned         hold_left    = 0;
  int unsigned         rx_mode_left = 0;
  int unsigned         pattern_cnt  = 0;
  rx_mode_e            rx_mode      = RX_ALWAYS;

  logic [WordBits-1:0] msg_buf[MaxMsgLen];

  word_crc_long_division_unit #(
    .WORD_BITS(WordBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .crc_o        (crc_o),
    .crc_is_zero_o(crc_is_zero_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shift the generator so its top bit lands just above the word; keep the low bits
  function automatic logic [WordBits-1:0] aligned_gen(input logic [PolyBits-1:0] value);
    logic [WordBits-1:0] p;
    int                  top;
    p   = value;
    top = -1;
    for (int b = 0; b < WordBits; b++) begin
      if (p[b]) top = b;
    end
    if (top < 0) return '0;
    p = p << (WordBits - 1 - top);
    return p << 1;
  endfunction

  // Divide one word into the running remainder, MSB first
  function automatic logic [WordBits-1:0] crc_fold(input logic [WordBits-1:0] rem,
                                                   input logic [WordBits-1:0] word,
                                                   input logic [WordBits-1:0] gen);
    logic [WordBits-1:0] r;
    logic                msb;
    r = rem ^ word;
    for (int i = 0; i < WordBits; i++) begin
      msb = r[WordBits-1];
      r   = r << 1;
      if (msb) r = r ^ gen;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CrcBits-1:0] got,
                                 input logic [CrcBits-1:0] want);
    // print the first few, count them all
    if (mismatches < MaxPrinted) begin
      $display("ERROR @%0t: %s: got %h, expected %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_result(input logic [CrcBits-1:0] crc, input logic zero);
    crc_result_t want;
    if (crc_expect_q.size() == 0) begin
      report_mismatch("result with nothing pending", crc, '0);
    end else begin
      want = crc_expect_q.pop_front();
      if (crc !== want.crc) report_mismatch("crc", crc, want.crc);
      if (zero !== want.zero) report_mismatch("crc_is_zero", CrcBits'(zero), CrcBits'(want.zero));
    end
  endtask

  // Offer one item, pausing first when a burst runs out; predict at acceptance
  task automatic send_word(input logic [WordBits-1:0] word, input logic last);
    int unsigned gap;
    crc_result_t res;
    gap = 0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_word_i <= word;
    last_word_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    running_rem = crc_fold(running_rem, word, gen_low);
    if (last) begin
      res.crc  = running_rem;
      res.zero = (running_rem == '0);
      crc_expect_q.push_back(res);
      running_rem = '0;
    end
  endtask

  // Send msg_buf as one message; optionally append its CRC so the check path runs
  task automatic send_message(input int unsigned len, input bit append_crc);
    logic [WordBits-1:0] rem;
    rem = '0;
    for (int i = 0; i < len; i++) rem = crc_fold(rem, msg_buf[i], gen_low);
    for (int i = 0; i < len; i++) begin
      send_word(msg_buf[i], (i == len - 1) && !append_crc);
    end
    if (append_crc) send_word(rem, 1'b1);
  endtask

  // Stop offering, wait for every pending result, then let the pipe settle
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_poly(input logic [PolyBits-1:0] value);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_low  = aligned_gen(value);
  endtask

  task automatic test_directed();
    // single-word messages at the data extremes, reset polynomial
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h8000, 1'b1);
    send_word(16'h0001, 1'b1);
    // carry linking words of one message
    send_word(16'h1234, 1'b0);
    send_word(16'hABCD, 1'b0);
    send_word(16'h5A5A, 1'b1);
    // message with its CRC appended must leave a zero remainder
    msg_buf[0] = 16'hDEAD;
    msg_buf[1] = 16'hBEEF;
    send_message(2, 1'b1);
  endtask

  task automatic test_poly_extremes();
    logic [PolyBits-1:0] polys[6];
    // zero, degree zero, all ones, top bit only, and two short generators
    polys = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h1021, 16'h0007};
    foreach (polys[i]) begin
      write_poly(polys[i]);
      send_word(16'hC3A5, 1'b0);
      send_word(16'hFFFF, 1'b1);
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering
    write_poly(wcld_pkg::PolyReset);
    sender_gaps  = 1'b0;
    hold_request = 300;
    repeat (60) send_word(WordBits'($urandom), 1'b1);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned         sent;
    int unsigned         len;
    bit                  append;
    logic [PolyBits-1:0] poly;
    for (int ph = 0; ph < 10; ph++) begin
      // pick a generator: extremes first, then mixed shapes
      case (ph)
        0: poly = 16'hFFFF;
        1: poly = 16'h0000;
        2: poly = 16'h0001;
        default: begin
          case ($urandom_range(0, 3))
            0: poly = PolyBits'($urandom);
            1: poly = PolyBits'($urandom) | 16'h8000;
            2: poly = PolyBits'($urandom) >> $urandom_range(1, 14);
            default: poly = wcld_pkg::PolyReset;
          endcase
        end
      endcase
      write_poly(poly);
      sender_gaps = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 96) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0: msg_buf[i] = '0;
            1: msg_buf[i] = '1;
            2: msg_buf[i] = WordBits'(1) << $urandom_range(0, WordBits - 1);
            default: msg_buf[i] = WordBits'($urandom);
          endcase
        end
        append = ($urandom_range(0, 4) == 0);
        send_message(len, append);
        sent += len + append;
      end
    end
  endtask

  // Receiver: check each result, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(crc_o, crc_is_zero_o);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      pattern_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready_i <= 1'b1;
          RX_LIGHT:  out_ready_i <= ($urandom_range(0, 3) != 0);
          RX_HEAVY:  out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= ((pattern_cnt % 5) >= 2);
        endcase
      end
    end
  end

  initial begin
    int unsigned waited;
    crc_result_t left;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    data_word_i <= '0;
    last_word_i <= 1'b0;
    out_ready_i <= 1'b0;
    gen_low     = aligned_gen(wcld_pkg::PolyReset);
    running_rem = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_poly_extremes();
    test_backpressure();
    test_random_stream();

    // wait out the pending results, then flag whatever never came
    in_valid_i <= 1'b0;
    waited = 0;
    while (crc_expect_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    while (crc_expect_q.size() != 0) begin
      left = crc_expect_q.pop_front();
      report_mismatch("result never arrived", '0, left.crc);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
